>>> hw/rtl/stq_pkg.sv
// stq_pkg: shared types and codes for the sorted timer queue
// used by stq_sub and sorted_timer_queue; depends on nothing
package stq_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int TIME_BITS_DEFAULT = 32;

  // operation codes on in_mode
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_ELAPSE = 2'd2;
  localparam logic [1:0] MODE_EXPIRE = 2'd3;

  // result codes on out_status
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  // compare flags from the shared subtractor
  typedef struct packed {
    logic ge;
    logic gt;
  } stq_cmp_t;

endpackage

>>> hw/rtl/sorted_timer_queue.sv
// sorted_timer_queue: top level of the sorted timer queue
// depends on stq_pkg and stq_sub; holds the slot memory and the sequencer
//
//   channel | direction | ports                                         | transfer when
//   in      | input     | mode timer_id deadline elapsed_time rearm     | in_valid & !in_stall
//   out     | output    | status fired_* head_* occupancy               | out_valid & !out_stall
//
// one item at a time; in_stall is high from acceptance until the result is
// handed to the output register. each memory entry visited is a registered
// read state, then a subtract/compare and write state. expire with re-arm
// runs a forward pass and then an insert pass. the one memory read port and
// the one shared subtractor make the entries go one at a time.
// reset clears the entry count and the sequencer; the slot memory is not
// cleared. the output register holds a result under out_stall while the next
// item is accepted and worked on.
module sorted_timer_queue #(
  parameter int DEPTH     = stq_pkg::DEPTH_DEFAULT,
  parameter int TIME_BITS = stq_pkg::TIME_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_mode,
  input  logic [7:0]                 in_timer_id,
  input  logic [31:0]                in_deadline,
  input  logic [31:0]                in_elapsed_time,
  input  logic                       in_rearm,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic                       out_fired_valid,
  output logic [7:0]                 out_fired_id,
  output logic                       out_head_valid,
  output logic [7:0]                 out_head_id,
  output logic [31:0]                out_head_time,
  output logic [$clog2(DEPTH+1)-1:0] out_occupancy
);
  import stq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_INS_START = 4'd1;
  localparam logic [3:0] ST_INS_RD    = 4'd2;
  localparam logic [3:0] ST_INS_EX    = 4'd3;
  localparam logic [3:0] ST_INS_PUT   = 4'd4;
  localparam logic [3:0] ST_FWD_RD    = 4'd5;
  localparam logic [3:0] ST_FWD_EX    = 4'd6;
  localparam logic [3:0] ST_HEAD_RD   = 4'd7;
  localparam logic [3:0] ST_DONE      = 4'd8;

  // slot memory, kept sorted by remaining time, slot 0 is the head
  logic [TIME_BITS-1:0] mem_time [DEPTH];
  logic [7:0]           mem_id   [DEPTH];

  logic [TIME_BITS-1:0] rd_time_r;
  logic [7:0]           rd_id_r;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [TIME_BITS-1:0] wr_time;
  logic [7:0]           wr_id;

  // control state
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          fired_v_r, fired_v_nxt;
  logic [7:0]    fired_id_r, fired_id_nxt;

  // operation held for the whole item
  logic [1:0]           mode_r, mode_nxt;
  logic [7:0]           id_r, id_nxt;
  logic [TIME_BITS-1:0] new_time_r, new_time_nxt;
  logic [TIME_BITS-1:0] delta_r, delta_nxt;
  logic                 rearm_r, rearm_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           o_status_r;
  logic                 o_fired_v_r;
  logic [7:0]           o_fired_id_r;
  logic                 o_head_v_r;
  logic [7:0]           o_head_id_r;
  logic [31:0]          o_head_time_r;
  logic [CW-1:0]        o_occ_r;
  logic                 out_load;
  logic [63:0]          head_time_ext;

  // shared subtractor
  logic [TIME_BITS-1:0] sub_b;
  logic [TIME_BITS-1:0] sub_sat;
  stq_cmp_t             sub_cmp;

  logic in_xfer;
  logic last_entry;
  logic match;
  logic shift_up;

  // insert compares slot time against the new time, the other passes age
  assign sub_b = (state_r == ST_INS_EX) ? new_time_r : delta_r;

  stq_sub #(
    .TIME_BITS(TIME_BITS)
  ) u_sub (
    .a   (rd_time_r),
    .b   (sub_b),
    .sat (sub_sat),
    .cmp (sub_cmp)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign last_entry = (CW'(idx_r + 1'b1) == count_r);

  // head moves only for a strictly greater head, later entries on greater-or-equal
  assign shift_up = (idx_r == '0) ? sub_cmp.gt : sub_cmp.ge;

  // the entry that leaves the queue in a forward pass
  assign match = (mode_r == MODE_EXPIRE) ? (idx_r == '0)
               : ((mode_r == MODE_REMOVE) && (rd_id_r == id_r));

  // memory: one write port, one registered read port at idx_r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_time[wr_addr] <= wr_time;
      mem_id[wr_addr]   <= wr_id;
    end
    rd_time_r <= mem_time[idx_r[AW-1:0]];
    rd_id_r   <= mem_id[idx_r[AW-1:0]];
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    fired_v_nxt  = fired_v_r;
    fired_id_nxt = fired_id_r;
    mode_nxt     = mode_r;
    id_nxt       = id_r;
    new_time_nxt = new_time_r;
    delta_nxt    = delta_r;
    rearm_nxt    = rearm_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_time      = new_time_r;
    wr_id        = id_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt     = in_mode;
          id_nxt       = in_timer_id;
          new_time_nxt = TIME_BITS'(in_deadline);
          delta_nxt    = (in_mode == MODE_REMOVE) ? '0 : TIME_BITS'(in_elapsed_time);
          rearm_nxt    = in_rearm;
          status_nxt   = STATUS_OK;
          fired_v_nxt  = 1'b0;
          fired_id_nxt = '0;
          found_nxt    = 1'b0;
          idx_nxt      = '0;
          if (in_mode == MODE_INSERT) begin
            state_nxt = ST_INS_START;
          end else if (count_r == '0) begin
            // nothing to scan
            case (in_mode)
              MODE_REMOVE: status_nxt = STATUS_NOT_FOUND;
              MODE_EXPIRE: status_nxt = STATUS_EMPTY;
              default:     status_nxt = STATUS_OK;
            endcase
            state_nxt = ST_HEAD_RD;
          end else begin
            state_nxt = ST_FWD_RD;
          end
        end
      end

      ST_INS_START: begin
        if (count_r == CW'(DEPTH)) begin
          status_nxt = STATUS_FULL;
          idx_nxt    = '0;
          state_nxt  = ST_HEAD_RD;
        end else if (count_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          count_nxt = CW'(1);
          idx_nxt   = '0;
          state_nxt = ST_HEAD_RD;
        end else begin
          // walk down from the tail, moving entries up one slot
          idx_nxt   = CW'(count_r - 1'b1);
          state_nxt = ST_INS_RD;
        end
      end

      ST_INS_RD: begin
        state_nxt = ST_INS_EX;
      end

      ST_INS_EX: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r + 1'b1);
        if (shift_up) begin
          wr_time = rd_time_r;
          wr_id   = rd_id_r;
          if (idx_r == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            idx_nxt   = CW'(idx_r - 1'b1);
            state_nxt = ST_INS_RD;
          end
        end else begin
          count_nxt = CW'(count_r + 1'b1);
          idx_nxt   = '0;
          state_nxt = ST_HEAD_RD;
        end
      end

      ST_INS_PUT: begin
        // new timer becomes the head
        wr_en     = 1'b1;
        wr_addr   = '0;
        count_nxt = CW'(count_r + 1'b1);
        idx_nxt   = '0;
        state_nxt = ST_HEAD_RD;
      end

      ST_FWD_RD: begin
        state_nxt = ST_FWD_EX;
      end

      ST_FWD_EX: begin
        wr_time = sub_sat;
        wr_id   = rd_id_r;
        if (found_r) begin
          // close the gap left by the removed entry
          wr_en   = 1'b1;
          wr_addr = AW'(idx_r - 1'b1);
        end else if (match) begin
          found_nxt = 1'b1;
          if (mode_r == MODE_EXPIRE) begin
            fired_v_nxt  = 1'b1;
            fired_id_nxt = rd_id_r;
            id_nxt       = rd_id_r;
          end
        end else if (mode_r == MODE_ELAPSE) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx_r);
        end

        if (last_entry) begin
          if (found_r || match) begin
            count_nxt = CW'(count_r - 1'b1);
          end else if (mode_r == MODE_REMOVE) begin
            status_nxt = STATUS_NOT_FOUND;
          end
          idx_nxt = '0;
          if (mode_r == MODE_EXPIRE && rearm_r) begin
            state_nxt = ST_INS_START;
          end else begin
            state_nxt = ST_HEAD_RD;
          end
        end else begin
          idx_nxt   = CW'(idx_r + 1'b1);
          state_nxt = ST_FWD_RD;
        end
      end

      ST_HEAD_RD: begin
        // slot 0 is read this cycle and shows up in DONE
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register takes the new result once the old one has gone
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign head_time_ext = 64'(rd_time_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    fired_v_r  <= fired_v_nxt;
    fired_id_r <= fired_id_nxt;
    mode_r     <= mode_nxt;
    id_r       <= id_nxt;
    new_time_r <= new_time_nxt;
    delta_r    <= delta_nxt;
    rearm_r    <= rearm_nxt;
    if (out_load) begin
      o_status_r    <= status_r;
      o_fired_v_r   <= fired_v_r;
      o_fired_id_r  <= fired_id_r;
      o_head_v_r    <= (count_r != '0);
      o_head_id_r   <= (count_r != '0) ? rd_id_r : 8'd0;
      o_head_time_r <= (count_r != '0) ? head_time_ext[31:0] : 32'd0;
      o_occ_r       <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_fired_valid = o_fired_v_r;
  assign out_fired_id    = o_fired_id_r;
  assign out_head_valid  = o_head_v_r;
  assign out_head_id     = o_head_id_r;
  assign out_head_time   = o_head_time_r;
  assign out_occupancy   = o_occ_r;

  // entry count never passes the memory depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // one item changes the count by at most one entry per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == CW'($past(count_r) + 1'b1) || count_r == CW'($past(count_r) - 1'b1)))
    else $error("entry count jumped");

  // a new result appears only out of the final state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside done state");

  // a popped timer always comes with a clean status
  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_fired_v_r) |-> (o_status_r == STATUS_OK))
    else $error("fired timer with error status");

  // head flag agrees with the reported occupancy
  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_head_v_r == (o_occ_r != '0)))
    else $error("head valid disagrees with occupancy");

endmodule

>>> hw/rtl/stq_sub.sv
// stq_sub: shared saturating subtractor and magnitude compare
// depends on stq_pkg for the compare flag struct
module stq_sub #(
  parameter int TIME_BITS = stq_pkg::TIME_BITS_DEFAULT
) (
  input  logic [TIME_BITS-1:0] a,
  input  logic [TIME_BITS-1:0] b,
  output logic [TIME_BITS-1:0] sat,
  output stq_pkg::stq_cmp_t    cmp
);
  import stq_pkg::*;

  logic [TIME_BITS:0] diff;
  logic               borrow;

  assign diff   = {1'b0, a} - {1'b0, b};
  assign borrow = diff[TIME_BITS];
  assign sat    = borrow ? '0 : diff[TIME_BITS-1:0];
  assign cmp.ge = !borrow;
  assign cmp.gt = !borrow && (diff[TIME_BITS-1:0] != '0);

endmodule

>>> tb/stq_checker.sv
// stq_checker: watches both channels of the sorted timer queue, keeps its own
// copy of the timer list and compares every result transfer field by field
// depends on stq_pkg for the operation and status codes
module stq_checker #(
  parameter int DEPTH = stq_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_mode,
  input  logic [7:0]                 in_timer_id,
  input  logic [31:0]                in_deadline,
  input  logic [31:0]                in_elapsed_time,
  input  logic                       in_rearm,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_status,
  input  logic                       out_fired_valid,
  input  logic [7:0]                 out_fired_id,
  input  logic                       out_head_valid,
  input  logic [7:0]                 out_head_id,
  input  logic [31:0]                out_head_time,
  input  logic [$clog2(DEPTH+1)-1:0] out_occupancy,
  output int                         fail_count,
  output int                         pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [1:0]       status;
    logic             fired_valid;
    logic [7:0]       fired_id;
    logic             head_valid;
    logic [7:0]       head_id;
    logic [31:0]      head_time;
    logic [OCC_W-1:0] occupancy;
  } timer_result_t;

  // shadow timer list, slot 0 is the head
  logic [31:0] timer_time [DEPTH];
  logic [7:0]  timer_id [DEPTH];
  int          timer_count;

  timer_result_t pending_results[$];
  timer_result_t oldest;
  int            err_total = 0;

  function automatic void age_timers(logic [31:0] delta);
    for (int i = 0; i < timer_count; i++)
      timer_time[i] = (timer_time[i] > delta) ? timer_time[i] - delta : 32'd0;
  endfunction

  function automatic void drop_timer(int pos);
    for (int i = pos; i + 1 < timer_count; i++) begin
      timer_time[i] = timer_time[i + 1];
      timer_id[i]   = timer_id[i + 1];
    end
    if (timer_count > 0) timer_count--;
  endfunction

  // ties go after the head but in front of equal later entries
  function automatic bit insert_timer(logic [7:0] id, logic [31:0] t);
    int pos;
    if (timer_count >= DEPTH) return 1'b0;
    if (timer_count == 0 || timer_time[0] > t) begin
      pos = 0;
    end else begin
      pos = 1;
      while (pos < timer_count && timer_time[pos] < t) pos++;
    end
    for (int i = timer_count; i > pos; i--) begin
      timer_time[i] = timer_time[i - 1];
      timer_id[i]   = timer_id[i - 1];
    end
    timer_time[pos] = t;
    timer_id[pos]   = id;
    timer_count++;
    return 1'b1;
  endfunction

  function automatic timer_result_t step_timer_queue(logic [1:0] mode, logic [7:0] id,
                                                     logic [31:0] dl, logic [31:0] el,
                                                     logic rearm);
    timer_result_t r;
    r = '0;
    r.status = STATUS_OK;
    case (mode)
      MODE_INSERT: begin
        if (!insert_timer(id, dl)) r.status = STATUS_FULL;
      end
      MODE_REMOVE: begin
        r.status = STATUS_NOT_FOUND;
        for (int i = 0; i < timer_count; i++) begin
          if (timer_id[i] == id) begin
            drop_timer(i);
            r.status = STATUS_OK;
            break;
          end
        end
      end
      MODE_ELAPSE: begin
        age_timers(el);
      end
      MODE_EXPIRE: begin
        if (timer_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.fired_valid = 1'b1;
          r.fired_id    = timer_id[0];
          drop_timer(0);
          age_timers(el);
          if (rearm) void'(insert_timer(r.fired_id, dl));
        end
      end
      default: ;
    endcase
    if (timer_count > 0) begin
      r.head_valid = 1'b1;
      r.head_id    = timer_id[0];
      r.head_time  = timer_time[0];
    end
    r.occupancy = OCC_W'(timer_count);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      timer_count = 0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          err_total++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("status", oldest.status, out_status);
          check_field("fired_valid", oldest.fired_valid, out_fired_valid);
          check_field("fired_id", oldest.fired_id, out_fired_id);
          check_field("head_valid", oldest.head_valid, out_head_valid);
          check_field("head_id", oldest.head_id, out_head_id);
          check_field("head_time", oldest.head_time, out_head_time);
          check_field("occupancy", oldest.occupancy, out_occupancy);
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(step_timer_queue(in_mode, in_timer_id, in_deadline,
                                                   in_elapsed_time, in_rearm));
    end
    pending    <= pending_results.size();
    fail_count <= err_total;
  end

endmodule

>>> tb/testbench.sv
// testbench: stimulus, output back-pressure, watchdog and verdict for the
// sorted timer queue; depends on stq_pkg, sorted_timer_queue and stq_checker
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_ITEMS  = 300;    // tail of the run with no random idle gaps or output stalls
  localparam int IDLE_LIMIT   = 2000;   // cycles without any transfer
  localparam int DRAIN_CYCLES = 150;    // extra wait after the last result for stray transfers

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 in_mode;
  logic [7:0]                 in_timer_id;
  logic [31:0]                in_deadline;
  logic [31:0]                in_elapsed_time;
  logic                       in_rearm;
  logic                       out_valid;
  logic                       out_stall;
  logic [1:0]                 out_status;
  logic                       out_fired_valid;
  logic [7:0]                 out_fired_id;
  logic                       out_head_valid;
  logic [7:0]                 out_head_id;
  logic [31:0]                out_head_time;
  logic [$clog2(DEPTH+1)-1:0] out_occupancy;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit quiet_tail = 1'b0;

  sorted_timer_queue dut (.*);

  stq_checker #(.DEPTH(DEPTH)) u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: a hung handshake on either side ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // result side back-pressure: random stall bursts between free-running stretches
  initial begin : receiver
    int run;
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        run = $urandom_range(1, 18);
      end else begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 40);
      end
      repeat (run) @(posedge clk);
    end
  end

  // puts one operation on the input channel and returns at the edge of its
  // transfer; valid stays high so the next call can follow back to back
  task automatic send_op(logic [1:0] mode, logic [7:0] id, logic [31:0] dl,
                         logic [31:0] el, logic rearm);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_timer_id     <= id;
    in_deadline     <= dl;
    in_elapsed_time <= el;
    in_rearm        <= rearm;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off the input until every outstanding result has been seen
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [1:0]  mode;
    logic [7:0]  id;
    logic [31:0] dl;
    logic [31:0] el;
    logic        rearm;
    bit          fill;
    int          pick;
    int          sel;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_INSERT;
    in_timer_id     <= '0;
    in_deadline     <= '0;
    in_elapsed_time <= '0;
    in_rearm        <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue corner cases: expire, remove and elapse with nothing held
    send_op(MODE_EXPIRE, 8'h00, 32'd0, 32'd0, 1'b1);
    send_op(MODE_REMOVE, 8'h2a, 32'd0, 32'd0, 1'b0);
    send_op(MODE_ELAPSE, 8'h00, 32'd0, 32'hffff_ffff, 1'b0);

    // fill past capacity: time extremes and a duplicate id; the last insert
    // finds the queue full
    for (int k = 0; k <= DEPTH; k++)
      send_op(MODE_INSERT, (k == 6) ? 8'd79 : 8'(k * 37 + 5),
              (k == 1) ? 32'hffff_ffff : 32'((k * 7) % 20), 32'd0, 1'b0);

    send_op(MODE_REMOVE, 8'd79, 32'd0, 32'd0, 1'b0);           // duplicate, nearest head goes
    send_op(MODE_REMOVE, 8'hff, 32'hffff_ffff, 32'd0, 1'b1);   // absent id
    send_op(MODE_ELAPSE, 8'd0, 32'd0, 32'd3, 1'b0);
    send_op(MODE_EXPIRE, 8'd0, 32'd100, 32'd1, 1'b1);          // pop and re-arm
    send_op(MODE_EXPIRE, 8'd0, 32'd0, 32'hffff_ffff, 1'b0);    // saturate the rest to zero
    send_op(MODE_ELAPSE, 8'd0, 32'd0, 32'd0, 1'b0);
    wait_for_results();

    // random part: alternating fill and drain phases so that both the full
    // and the empty corners are visited many times
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > 0 && n % 400 == 0) wait_for_results();
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 18));

      fill = ((n / 150) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (pick < (fill ? 60 : 20))      mode = MODE_INSERT;
      else if (pick < (fill ? 72 : 45)) mode = MODE_REMOVE;
      else if (pick < (fill ? 84 : 65)) mode = MODE_ELAPSE;
      else                              mode = MODE_EXPIRE;

      // a small id pool keeps removes hitting; the full range toggles every bit
      id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 23));

      sel = $urandom_range(0, 15);
      dl  = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hffff_ffff :
            (sel < 5) ? $urandom : 32'($urandom_range(0, 60));
      sel = $urandom_range(0, 15);
      el  = (sel == 0) ? 32'hffff_ffff : (sel == 1) ? $urandom :
            (sel == 2) ? 32'd0 : 32'($urandom_range(0, 8));
      rearm = $urandom_range(0, 1);

      send_op(mode, id, dl, el, rearm);
    end

    // let the last results come out, then a little more for stray transfers
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
